// ===== design/c_syntax_balance_checker_macros.svh =====
// Assertion macros used by the balance checker scanner module.
`ifndef C_SYNTAX_BALANCE_CHECKER_MACROS_SVH
`define C_SYNTAX_BALANCE_CHECKER_MACROS_SVH

// Checks a property on every rising edge of clk while rst is low.
`define CSBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every rising edge of clk, during reset as well.
`define CSBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/csbc_pkg.sv =====
// Types and constants shared by the C syntax balance checker.
`timescale 1ns / 1ps
`default_nettype none

package csbc_pkg;

  // Width of the brace and parenthesis depth counters.
  localparam int unsigned DEPTH_BITS = 16;

  // Error codes reported on the result channel.
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_BRACE   = 3'd1,
    ERR_PAREN   = 3'd2,
    ERR_DQUOTE  = 3'd3,
    ERR_SQUOTE  = 3'd4,
    ERR_COMMENT = 3'd5
  } err_t;

  // Character codes that the scanner reacts to.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // Previous-byte value meaning no byte is held.
  localparam logic [8:0] PREV_NONE = 9'h100;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } item_t;

  // One result beat as produced by the scanner.
  typedef struct packed {
    err_t err_code;
    logic is_final;
  } res_t;

endpackage

`default_nettype wire

// ===== design/csbc_in_if.sv =====
// Valid/ready channel carrying source bytes and the end marker.
`timescale 1ns / 1ps
`default_nettype none

interface csbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_mark;

  modport source (output valid, output ch, output end_mark, input ready);
  modport sink (input valid, input ch, input end_mark, output ready);
endinterface

`default_nettype wire

// ===== design/csbc_out_if.sv =====
// Valid/ready channel carrying check results.
`timescale 1ns / 1ps
`default_nettype none

interface csbc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] err_code;
  logic       is_final;

  modport source (output valid, output err_code, output is_final, input ready);
  modport sink (input valid, input err_code, input is_final, output ready);
endinterface

`default_nettype wire

// ===== design/csbc_in_stage.sv =====
// Input register stage: captures one beat and hands it to the scanner.
`timescale 1ns / 1ps
`default_nettype none

module csbc_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  csbc_in_if.sink            text,
  input  wire logic          take,
  output csbc_pkg::item_t    item,
  output logic               fire
);

  logic            held;
  logic            held_next;
  csbc_pkg::item_t item_reg;
  logic            accept;

  // The register may refill in the same cycle that its beat moves on.
  assign text.ready = !held || take;
  assign accept     = text.valid && text.ready;
  assign fire       = held && take;
  assign item       = item_reg;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = 1'b1;
    end else if (fire) begin
      held_next = 1'b0;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_reg.ch       <= text.ch;
      item_reg.end_mark <= text.end_mark;
    end
  end

endmodule

`default_nettype wire

// ===== design/csbc_scan.sv =====
// Scanner state and its update logic for one byte or end marker.
`timescale 1ns / 1ps
`default_nettype none

`include "c_syntax_balance_checker_macros.svh"

module csbc_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire csbc_pkg::item_t   item,
  output csbc_pkg::res_t         res
);

  localparam logic [csbc_pkg::DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [csbc_pkg::DEPTH_BITS-1:0] DEPTH_ONE =
    csbc_pkg::DEPTH_BITS'(1);

  logic                            in_comment, in_comment_next;
  logic                            in_string, in_string_next;
  logic                            in_charlit, in_charlit_next;
  logic                            escape_on, escape_on_next;
  logic [8:0]                      prev_byte, prev_byte_next;
  logic [csbc_pkg::DEPTH_BITS-1:0] brace_depth, brace_depth_next;
  logic [csbc_pkg::DEPTH_BITS-1:0] paren_depth, paren_depth_next;
  csbc_pkg::err_t                  latched_error, latched_error_next;
  csbc_pkg::err_t                  final_code;
  logic [7:0]                      b;
  logic                            is_break;

  assign b        = item.ch;
  assign is_break = (b == csbc_pkg::CH_LF) || (b == csbc_pkg::CH_VT);

  // Next state and result for the beat in the input register.
  always_comb begin
    in_comment_next    = in_comment;
    in_string_next     = in_string;
    in_charlit_next    = in_charlit;
    escape_on_next     = escape_on;
    prev_byte_next     = prev_byte;
    brace_depth_next   = brace_depth;
    paren_depth_next   = paren_depth;
    latched_error_next = latched_error;
    final_code         = latched_error;

    if (item.end_mark) begin
      // Final checks in fixed order, then everything returns to reset.
      if (latched_error == csbc_pkg::ERR_NONE) begin
        priority if (brace_depth != '0) begin
          final_code = csbc_pkg::ERR_BRACE;
        end else if (paren_depth != '0) begin
          final_code = csbc_pkg::ERR_PAREN;
        end else if (in_comment) begin
          final_code = csbc_pkg::ERR_COMMENT;
        end else if (in_string) begin
          final_code = csbc_pkg::ERR_DQUOTE;
        end else if (in_charlit) begin
          final_code = csbc_pkg::ERR_SQUOTE;
        end else begin
          final_code = csbc_pkg::ERR_NONE;
        end
      end
      in_comment_next    = 1'b0;
      in_string_next     = 1'b0;
      in_charlit_next    = 1'b0;
      escape_on_next     = 1'b0;
      prev_byte_next     = csbc_pkg::PREV_NONE;
      brace_depth_next   = '0;
      paren_depth_next   = '0;
      latched_error_next = csbc_pkg::ERR_NONE;
    end else if (latched_error == csbc_pkg::ERR_NONE) begin
      if (in_comment) begin
        // Inside a comment only the closing pair matters.
        if (prev_byte == {1'b0, csbc_pkg::CH_STAR} && b == csbc_pkg::CH_SLASH) begin
          in_comment_next = 1'b0;
          prev_byte_next  = csbc_pkg::PREV_NONE;
        end else begin
          prev_byte_next = {1'b0, b};
        end
      end else if (b == csbc_pkg::CH_BSL) begin
        escape_on_next = !escape_on;
      end else begin
        escape_on_next = 1'b0;
        priority if (in_string) begin
          if (is_break) begin
            latched_error_next = csbc_pkg::ERR_DQUOTE;
          end else if (b == csbc_pkg::CH_DQUOTE && !escape_on) begin
            in_string_next = 1'b0;
          end
        end else if (in_charlit) begin
          if (is_break) begin
            latched_error_next = csbc_pkg::ERR_SQUOTE;
          end else if (b == csbc_pkg::CH_SQUOTE && !escape_on) begin
            in_charlit_next = 1'b0;
          end
        end else if (b == csbc_pkg::CH_DQUOTE) begin
          in_string_next = 1'b1;
        end else if (b == csbc_pkg::CH_SQUOTE) begin
          in_charlit_next = 1'b1;
        end else if (b == csbc_pkg::CH_LBRACE) begin
          if (brace_depth == DEPTH_MAX) begin
            latched_error_next = csbc_pkg::ERR_BRACE;
          end else begin
            brace_depth_next = brace_depth + DEPTH_ONE;
          end
        end else if (b == csbc_pkg::CH_RBRACE) begin
          if (brace_depth == '0) begin
            latched_error_next = csbc_pkg::ERR_BRACE;
          end else begin
            brace_depth_next = brace_depth - DEPTH_ONE;
          end
        end else if (b == csbc_pkg::CH_LPAREN) begin
          if (paren_depth == DEPTH_MAX) begin
            latched_error_next = csbc_pkg::ERR_PAREN;
          end else begin
            paren_depth_next = paren_depth + DEPTH_ONE;
          end
        end else if (b == csbc_pkg::CH_RPAREN) begin
          if (paren_depth == '0) begin
            latched_error_next = csbc_pkg::ERR_PAREN;
          end else begin
            paren_depth_next = paren_depth - DEPTH_ONE;
          end
        end else if (prev_byte == {1'b0, csbc_pkg::CH_SLASH} && b == csbc_pkg::CH_STAR) begin
          in_comment_next = 1'b1;
          prev_byte_next  = csbc_pkg::PREV_NONE;
        end else begin
          prev_byte_next = {1'b0, b};
        end
      end
    end

    res.err_code = item.end_mark ? final_code : latched_error_next;
    res.is_final = item.end_mark;
  end

  // Scanner state, updated once per beat that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment    <= 1'b0;
      in_string     <= 1'b0;
      in_charlit    <= 1'b0;
      escape_on     <= 1'b0;
      prev_byte     <= csbc_pkg::PREV_NONE;
      brace_depth   <= '0;
      paren_depth   <= '0;
      latched_error <= csbc_pkg::ERR_NONE;
    end else if (fire) begin
      in_comment    <= in_comment_next;
      in_string     <= in_string_next;
      in_charlit    <= in_charlit_next;
      escape_on     <= escape_on_next;
      prev_byte     <= prev_byte_next;
      brace_depth   <= brace_depth_next;
      paren_depth   <= paren_depth_next;
      latched_error <= latched_error_next;
    end
  end

  // At most one of comment, string and character literal is open.
  `CSBC_ASSERT(a_one_context, $onehot0({in_comment, in_string, in_charlit}), "more than one lexical context open")
  // A pending escape never survives into a comment.
  `CSBC_ASSERT(a_no_escape_in_comment, in_comment |-> !escape_on, "escape flag set inside a comment")
  // A latched error holds until an end marker clears it.
  `CSBC_ASSERT(a_error_sticky, (latched_error != csbc_pkg::ERR_NONE) && !(fire && item.end_mark) |=> $stable(latched_error), "latched error changed before end marker")
  // An end marker leaves the scanner in its reset state.
  `CSBC_ASSERT(a_end_clears, fire && item.end_mark |=> (brace_depth == '0) && (paren_depth == '0) && (latched_error == csbc_pkg::ERR_NONE) && (prev_byte == csbc_pkg::PREV_NONE), "end marker did not clear state")

endmodule

`default_nettype wire

// ===== design/csbc_out_stage.sv =====
// Result register stage driving the result channel.
`timescale 1ns / 1ps
`default_nettype none

module csbc_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire csbc_pkg::res_t   res,
  output logic                  take,
  csbc_out_if.source            result
);

  logic           full;
  logic           full_next;
  csbc_pkg::res_t res_reg;

  // A new result may enter when the register is empty or being drained.
  assign take            = !full || result.ready;
  assign result.valid    = full;
  assign result.err_code = res_reg.err_code;
  assign result.is_final = res_reg.is_final;

  always_comb begin
    full_next = full;
    if (fire) begin
      full_next = 1'b1;
    end else if (result.ready) begin
      full_next = 1'b0;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      res_reg <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/c_syntax_balance_checker.sv =====
// Top level of the C syntax balance checker.
//
// The block scans C source text one byte per beat on the text channel and
// answers every beat with exactly one beat on the result channel. A byte
// beat returns the latched error code (zero while the text is clean) with
// is_final low; a beat with end_mark set runs the closing checks (braces,
// parentheses, comment, string, character literal), returns the first
// failure with is_final high, and clears all scanner state for the next file.
// An accepted beat waits in the input register; when it moves on, its result is
// written to the result register, from which the receiver then takes it.
// Throughput is one beat per cycle while the receiver does not stall, bounded
// by the state update of the scanner, which each beat depends on from the one
// before.
// When the receiver stalls, the result register holds its beat, then the
// input register fills, and text.ready drops until a result is taken.
// A synchronous reset on rst empties both registers and returns the scanner
// to its clean state; there is no configuration and no memory to clear.
`timescale 1ns / 1ps
`default_nettype none

module c_syntax_balance_checker (
  input  wire logic   clk,
  input  wire logic   rst,
  csbc_in_if.sink     text,
  csbc_out_if.source  result
);

  csbc_pkg::item_t item;
  csbc_pkg::res_t  res;
  logic            fire;
  logic            take;

  // Input register.
  csbc_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .take (take),
    .item (item),
    .fire (fire)
  );

  // Scanner state and update logic.
  csbc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  // Result register.
  csbc_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .res    (res),
    .take   (take),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== test/csbc_result_checker.sv =====
// Result checker for the C syntax balance checker: scan predictor and beat comparison.
`timescale 1ns / 1ps

module csbc_result_checker (
  input  logic        clk,
  input  logic        rst,
  csbc_in_if          text,
  csbc_out_if         result,
  input  logic        drain_done,
  output int unsigned fail_count,
  output int unsigned outstanding,
  output int unsigned final_count
);

  // Shadow copy of the scanner state.
  logic                            in_cmt;
  logic                            in_str;
  logic                            in_chr;
  logic                            esc;
  logic [8:0]                      last_code;
  logic [csbc_pkg::DEPTH_BITS-1:0] braces;
  logic [csbc_pkg::DEPTH_BITS-1:0] parens;
  csbc_pkg::err_t                  err_latch;

  // Results predicted for accepted text beats, oldest first.
  csbc_pkg::res_t pending_results[$];
  logic           drain_seen;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function void clear_scan();
    in_cmt    = 1'b0;
    in_str    = 1'b0;
    in_chr    = 1'b0;
    esc       = 1'b0;
    last_code = csbc_pkg::PREV_NONE;
    braces    = '0;
    parens    = '0;
    err_latch = csbc_pkg::ERR_NONE;
  endfunction

  // Advances the scanner by one source byte while no error is latched.
  function void scan_byte(input logic [7:0] c);
    logic brk;
    brk = (c == csbc_pkg::CH_LF) || (c == csbc_pkg::CH_VT);
    if (in_cmt) begin
      // Inside a comment every byte is remembered; a star then slash closes it.
      if (last_code == {1'b0, csbc_pkg::CH_STAR} && c == csbc_pkg::CH_SLASH) begin
        in_cmt    = 1'b0;
        last_code = csbc_pkg::PREV_NONE;
      end else begin
        last_code = {1'b0, c};
      end
    end else if (c == csbc_pkg::CH_BSL) begin
      esc = !esc;
    end else begin
      if (in_str) begin
        if (brk) err_latch = csbc_pkg::ERR_DQUOTE;
        else if (c == csbc_pkg::CH_DQUOTE && !esc) in_str = 1'b0;
      end else if (in_chr) begin
        if (brk) err_latch = csbc_pkg::ERR_SQUOTE;
        else if (c == csbc_pkg::CH_SQUOTE && !esc) in_chr = 1'b0;
      end else if (c == csbc_pkg::CH_DQUOTE) begin
        in_str = 1'b1;
      end else if (c == csbc_pkg::CH_SQUOTE) begin
        in_chr = 1'b1;
      end else if (c == csbc_pkg::CH_LBRACE) begin
        if (&braces) err_latch = csbc_pkg::ERR_BRACE;
        else braces = braces + 1'b1;
      end else if (c == csbc_pkg::CH_RBRACE) begin
        if (braces == '0) err_latch = csbc_pkg::ERR_BRACE;
        else braces = braces - 1'b1;
      end else if (c == csbc_pkg::CH_LPAREN) begin
        if (&parens) err_latch = csbc_pkg::ERR_PAREN;
        else parens = parens + 1'b1;
      end else if (c == csbc_pkg::CH_RPAREN) begin
        if (parens == '0) err_latch = csbc_pkg::ERR_PAREN;
        else parens = parens - 1'b1;
      end else if (last_code == {1'b0, csbc_pkg::CH_SLASH} && c == csbc_pkg::CH_STAR) begin
        in_cmt    = 1'b1;
        last_code = csbc_pkg::PREV_NONE;
      end else begin
        last_code = {1'b0, c};
      end
      esc = 1'b0;
    end
  endfunction

  // Works out the result beat that one text beat produces.
  function csbc_pkg::res_t predict_result(input logic [7:0] c, input logic endm);
    csbc_pkg::res_t r;
    csbc_pkg::err_t code;
    if (!endm) begin
      if (err_latch == csbc_pkg::ERR_NONE) scan_byte(c);
      r.err_code = err_latch;
      r.is_final = 1'b0;
    end else begin
      // Closing checks in priority order, unless an error is already held.
      code = err_latch;
      if (code == csbc_pkg::ERR_NONE) begin
        if (braces != '0) code = csbc_pkg::ERR_BRACE;
        else if (parens != '0) code = csbc_pkg::ERR_PAREN;
        else if (in_cmt) code = csbc_pkg::ERR_COMMENT;
        else if (in_str) code = csbc_pkg::ERR_DQUOTE;
        else if (in_chr) code = csbc_pkg::ERR_SQUOTE;
      end
      clear_scan();
      r.err_code = code;
      r.is_final = 1'b1;
    end
    return r;
  endfunction

  // Predict on accepted text beats and compare accepted result beats.
  always @(posedge clk) begin
    csbc_pkg::res_t want;
    if (rst) begin
      clear_scan();
      pending_results.delete();
      drain_seen  = 1'b0;
      fail_count  = 0;
      final_count = 0;
      outstanding <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat (code %0d, final %0b) with nothing expected",
                                    result.err_code, result.is_final));
        end else begin
          want = pending_results.pop_front();
          if (result.err_code !== 3'(want.err_code))
            report_mismatch($sformatf("err_code %0d, expected %0d (%s)", result.err_code,
                                      want.err_code, want.err_code.name()));
          if (result.is_final !== want.is_final)
            report_mismatch($sformatf("is_final %0b, expected %0b", result.is_final,
                                      want.is_final));
          if (want.is_final) final_count++;
        end
      end
      if (text.valid && text.ready)
        pending_results.push_back(predict_result(text.ch, text.end_mark));
      // Anything still waiting once the top has drained the block was lost.
      if (drain_done && !drain_seen) begin
        drain_seen = 1'b1;
        if (pending_results.size() != 0)
          report_mismatch($sformatf("%0d expected result beats never arrived",
                                    pending_results.size()));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the balance checker testbench: clock, reset, source text, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RANDOM_BEATS   = 1800;
  localparam int unsigned CALM_BEATS     = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  logic drain_done;

  csbc_in_if  text();
  csbc_out_if result();

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned final_count;
  int unsigned sent_beats   = 0;
  int unsigned sent_files   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  string       plain_set    = "abcdxyz_019 ;=+-*/,.<>\t\n";

  c_syntax_balance_checker u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .result (result)
  );

  csbc_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .text        (text),
    .result      (result),
    .drain_done  (drain_done),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .final_count (final_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (text.valid && text.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a beat", quiet_cycles);
        $display("FAIL c_syntax_balance_checker");
        $finish;
      end
    end
  end

  // Result receiver: ready high, with random stall bursts while stall_pct is set.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      result.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Presents one text beat, with an optional idle burst first, and waits for it to go.
  task automatic send_beat(input logic [7:0] c, input logic e);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      text.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    text.valid    <= 1'b1;
    text.ch       <= c;
    text.end_mark <= e;
    @(posedge clk);
    while (!text.ready) @(posedge clk);
    @(negedge clk);
    sent_beats++;
    if (e) sent_files++;
  endtask

  // A quoted literal with random body bytes and occasional escapes.
  task automatic put_literal(input logic [7:0] q);
    logic [7:0] c;
    send_beat(q, 1'b0);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(csbc_pkg::CH_BSL, 1'b0);
        case ($urandom_range(0, 3))
          0:       c = q;
          1:       c = csbc_pkg::CH_BSL;
          2:       c = "n";
          default: c = (q == csbc_pkg::CH_DQUOTE) ? csbc_pkg::CH_SQUOTE : csbc_pkg::CH_DQUOTE;
        endcase
      end else begin
        c = 8'($urandom_range(8'h20, 8'hFF));
        if (c == q || c == csbc_pkg::CH_BSL) c = "a";
      end
      send_beat(c, 1'b0);
    end
    send_beat(q, 1'b0);
  endtask

  // A block comment holding arbitrary bytes.
  task automatic put_comment();
    send_beat(csbc_pkg::CH_SLASH, 1'b0);
    send_beat(csbc_pkg::CH_STAR, 1'b0);
    repeat ($urandom_range(0, 8)) send_beat(8'($urandom_range(0, 255)), 1'b0);
    send_beat(csbc_pkg::CH_STAR, 1'b0);
    send_beat(csbc_pkg::CH_SLASH, 1'b0);
  endtask

  // One random source file, mostly well formed, sometimes broken, then its end marker.
  task automatic write_random_file();
    int unsigned start;
    int unsigned target;
    int unsigned r;
    int unsigned open_b;
    int unsigned open_p;
    start  = sent_beats;
    target = $urandom_range(4, 60);
    open_b = 0;
    open_p = 0;
    while (sent_beats - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_beat(plain_set[$urandom_range(0, plain_set.len() - 1)], 1'b0);
      end else if (r < 48) begin
        send_beat(csbc_pkg::CH_LBRACE, 1'b0);
        open_b++;
      end else if (r < 54) begin
        if (open_b != 0) begin
          send_beat(csbc_pkg::CH_RBRACE, 1'b0);
          open_b--;
        end
      end else if (r < 62) begin
        send_beat(csbc_pkg::CH_LPAREN, 1'b0);
        open_p++;
      end else if (r < 68) begin
        if (open_p != 0) begin
          send_beat(csbc_pkg::CH_RPAREN, 1'b0);
          open_p--;
        end
      end else if (r < 76) begin
        put_literal(csbc_pkg::CH_DQUOTE);
      end else if (r < 82) begin
        put_literal(csbc_pkg::CH_SQUOTE);
      end else if (r < 90) begin
        put_comment();
      end else if (r < 94) begin
        send_beat(csbc_pkg::CH_BSL, 1'b0);
      end else begin
        send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    // Close everything in most files; break the rest in one of several ways.
    if ($urandom_range(0, 9) >= 2) begin
      repeat (open_b) send_beat(csbc_pkg::CH_RBRACE, 1'b0);
      repeat (open_p) send_beat(csbc_pkg::CH_RPAREN, 1'b0);
    end else begin
      case ($urandom_range(0, 5))
        0: send_beat(csbc_pkg::CH_RBRACE, 1'b0);
        1: send_beat(csbc_pkg::CH_RPAREN, 1'b0);
        2: begin
          send_beat(csbc_pkg::CH_DQUOTE, 1'b0);
          send_beat(csbc_pkg::CH_LF, 1'b0);
        end
        3: begin
          send_beat(csbc_pkg::CH_SQUOTE, 1'b0);
          send_beat(csbc_pkg::CH_VT, 1'b0);
        end
        4: begin
          send_beat(csbc_pkg::CH_SLASH, 1'b0);
          send_beat(csbc_pkg::CH_STAR, 1'b0);
        end
        default: ;
      endcase
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Short hand-written files, one per error kind and closing check.
  task automatic run_directed();
    // Clean file: byte extremes, nested pairs and a comment with bytes inside.
    send_beat(8'h00, 1'b0);
    send_beat(csbc_pkg::CH_LBRACE, 1'b0);
    send_beat(csbc_pkg::CH_LPAREN, 1'b0);
    send_beat(csbc_pkg::CH_RPAREN, 1'b0);
    send_beat(csbc_pkg::CH_RBRACE, 1'b0);
    send_beat(csbc_pkg::CH_SLASH, 1'b0);
    send_beat(csbc_pkg::CH_STAR, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(csbc_pkg::CH_STAR, 1'b0);
    send_beat(csbc_pkg::CH_SLASH, 1'b0);
    send_beat(8'hFF, 1'b1);
    // Closers with nothing open; the byte after the error is ignored.
    send_beat(csbc_pkg::CH_RBRACE, 1'b0);
    send_beat(csbc_pkg::CH_LPAREN, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(csbc_pkg::CH_RPAREN, 1'b0);
    send_beat(8'h00, 1'b1);
    // An escaped quote keeps the string open, so the line feed is an error.
    send_beat(csbc_pkg::CH_DQUOTE, 1'b0);
    send_beat(csbc_pkg::CH_BSL, 1'b0);
    send_beat(csbc_pkg::CH_DQUOTE, 1'b0);
    send_beat(csbc_pkg::CH_LF, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(csbc_pkg::CH_SQUOTE, 1'b0);
    send_beat(csbc_pkg::CH_VT, 1'b0);
    send_beat(8'h00, 1'b1);
    // Closing checks: comment alone, then braces ahead of parens ahead of comment.
    send_beat(csbc_pkg::CH_SLASH, 1'b0);
    send_beat(csbc_pkg::CH_STAR, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(csbc_pkg::CH_LBRACE, 1'b0);
    send_beat(csbc_pkg::CH_LPAREN, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(csbc_pkg::CH_LPAREN, 1'b0);
    send_beat(csbc_pkg::CH_SLASH, 1'b0);
    send_beat(csbc_pkg::CH_STAR, 1'b0);
    send_beat(8'h00, 1'b1);
    // Open literals at the end, then an empty file.
    send_beat(csbc_pkg::CH_DQUOTE, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(csbc_pkg::CH_SQUOTE, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b1);
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned rand_start;
    rst           = 1'b1;
    drain_done    = 1'b0;
    text.valid    = 1'b0;
    text.ch       = 8'h00;
    text.end_mark = 1'b0;
    result.ready  = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    idle_pct  = 20;
    stall_pct = 20;
    run_directed();

    // Random files, each with its own idling mix; the last stretch runs clean.
    rand_start = sent_beats;
    while (sent_beats - rand_start < RANDOM_BEATS) begin
      if (sent_beats - rand_start >= RANDOM_BEATS - CALM_BEATS) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = $urandom_range(5, 40);
        stall_pct = $urandom_range(5, 40);
      end
      write_random_file();
    end
    text.valid <= 1'b0;

    // Drain, allow for the input and result registers, then let the checker close out.
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Run covered %0d text beats in %0d files: directed error cases and",
             sent_beats, sent_files);
    $display("random source under idling and stalls; %0d end verdicts checked.",
             final_count);
    if (fail_count == 0) begin
      $display("PASS c_syntax_balance_checker");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL c_syntax_balance_checker");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/csbc_pkg.sv
design/csbc_in_if.sv
design/csbc_out_if.sv
design/csbc_in_stage.sv
design/csbc_scan.sv
design/csbc_out_stage.sv
design/c_syntax_balance_checker.sv
test/csbc_result_checker.sv
test/tb_top.sv
